/* src/lcdn_pkg.sv */
package lcdn_pkg;

    // Request operation codes.
    typedef enum logic [2:0] {
        OP_INIT    = 3'd0,
        OP_CMD     = 3'd1,
        OP_CHAR    = 3'd2,
        OP_CLEAR   = 3'd3,
        OP_CURSOR  = 3'd4,
        OP_HEX_BYTE = 3'd5,
        OP_DECIMAL = 3'd6,
        OP_HEX_NIB = 3'd7
    } t_op;

    // Where the byte of a microinstruction comes from.
    typedef enum logic [2:0] {
        SRC_CONST  = 3'd0,
        SRC_BYTE   = 3'd1,
        SRC_ADDR   = 3'd2,
        SRC_HEX_HI = 3'd3,
        SRC_HEX_LO = 3'd4,
        SRC_DIGIT  = 3'd5
    } t_src;

    // Hold time after the final strobe of a microinstruction.
    typedef enum logic [2:0] {
        HOLD_30000 = 3'd0,
        HOLD_5000  = 3'd1,
        HOLD_100   = 3'd2,
        HOLD_37    = 3'd3,
        HOLD_41    = 3'd4,
        HOLD_1640  = 3'd5,
        HOLD_EXEC  = 3'd6
    } t_hold;

    // A microinstruction emits pin states from its start phase up to phase 3:
    // phase 0 high nibble strobe, 1 high nibble settle, 2 low nibble strobe,
    // 3 low nibble hold.
    localparam logic [1:0] PH_BYTE = 2'd0;
    localparam logic [1:0] PH_NIB  = 2'd2;
    localparam logic [1:0] PH_WAIT = 2'd3;
    localparam logic [1:0] PH_LAST = 2'd3;

    localparam int PC_W = 5;
    typedef logic [PC_W-1:0] t_pc;

    // Program entry points.
    localparam t_pc PC_INIT     = 5'd0;
    localparam t_pc PC_CLEAR    = 5'd8;
    localparam t_pc PC_CMD      = 5'd9;
    localparam t_pc PC_CHAR     = 5'd10;
    localparam t_pc PC_CURSOR   = 5'd11;
    localparam t_pc PC_HEX_BYTE = 5'd12;
    localparam t_pc PC_HEX_NIB  = 5'd13;
    localparam t_pc PC_DECIMAL  = 5'd14;

    typedef struct packed {
        logic [1:0] start_ph;
        t_src       src;
        logic       rs;
        t_hold      hold;
        logic [7:0] k;
        logic       loop;
        logic       fin;
    } t_uword;

    function automatic t_uword uw(logic [1:0] ph, t_src s, logic rs, t_hold h,
                                  logic [7:0] k, logic lp, logic fin);
        t_uword w;
        w.start_ph = ph;
        w.src      = s;
        w.rs       = rs;
        w.hold     = h;
        w.k        = k;
        w.loop     = lp;
        w.fin      = fin;
        return w;
    endfunction

    // Microcode store. The decimal digit word loops on itself while the
    // remaining quotient is nonzero.
    function automatic t_uword ucode(t_pc pc);
        t_uword w;
        unique case (pc)
            5'd0:    w = uw(PH_WAIT, SRC_CONST, 1'b0, HOLD_30000, 8'h00, 1'b0, 1'b0);
            5'd1:    w = uw(PH_NIB,  SRC_CONST, 1'b0, HOLD_5000,  8'h03, 1'b0, 1'b0);
            5'd2:    w = uw(PH_NIB,  SRC_CONST, 1'b0, HOLD_100,   8'h03, 1'b0, 1'b0);
            5'd3:    w = uw(PH_NIB,  SRC_CONST, 1'b0, HOLD_37,    8'h03, 1'b0, 1'b0);
            5'd4:    w = uw(PH_NIB,  SRC_CONST, 1'b0, HOLD_37,    8'h02, 1'b0, 1'b0);
            5'd5:    w = uw(PH_BYTE, SRC_CONST, 1'b0, HOLD_37,    8'h28, 1'b0, 1'b0);
            5'd6:    w = uw(PH_BYTE, SRC_CONST, 1'b0, HOLD_37,    8'h0c, 1'b0, 1'b0);
            5'd7:    w = uw(PH_BYTE, SRC_CONST, 1'b0, HOLD_37,    8'h06, 1'b0, 1'b0);
            5'd8:    w = uw(PH_BYTE, SRC_CONST, 1'b0, HOLD_1640,  8'h01, 1'b0, 1'b1);
            5'd9:    w = uw(PH_BYTE, SRC_BYTE,  1'b0, HOLD_EXEC,  8'h00, 1'b0, 1'b1);
            5'd10:   w = uw(PH_BYTE, SRC_BYTE,  1'b1, HOLD_41,    8'h00, 1'b0, 1'b1);
            5'd11:   w = uw(PH_BYTE, SRC_ADDR,  1'b0, HOLD_37,    8'h00, 1'b0, 1'b1);
            5'd12:   w = uw(PH_BYTE, SRC_HEX_HI, 1'b1, HOLD_41,   8'h00, 1'b0, 1'b0);
            5'd13:   w = uw(PH_BYTE, SRC_HEX_LO, 1'b1, HOLD_41,   8'h00, 1'b0, 1'b1);
            5'd14:   w = uw(PH_BYTE, SRC_CONST, 1'b0, HOLD_37,    8'h04, 1'b0, 1'b0);
            5'd15:   w = uw(PH_BYTE, SRC_DIGIT, 1'b1, HOLD_41,    8'h00, 1'b1, 1'b0);
            5'd16:   w = uw(PH_BYTE, SRC_CONST, 1'b0, HOLD_37,    8'h06, 1'b0, 1'b1);
            default: w = uw(PH_BYTE, SRC_CONST, 1'b0, HOLD_37,    8'h00, 1'b0, 1'b1);
        endcase
        return w;
    endfunction

    // Entry point of each operation.
    function automatic t_pc entry(t_op op);
        t_pc pc;
        unique case (op)
            OP_INIT:     pc = PC_INIT;
            OP_CMD:      pc = PC_CMD;
            OP_CHAR:     pc = PC_CHAR;
            OP_CLEAR:    pc = PC_CLEAR;
            OP_CURSOR:   pc = PC_CURSOR;
            OP_HEX_BYTE: pc = PC_HEX_BYTE;
            OP_DECIMAL:  pc = PC_DECIMAL;
            default:     pc = PC_HEX_NIB;
        endcase
        return pc;
    endfunction

    // ASCII hex digit, upper-case letters.
    function automatic logic [7:0] hex_char(logic [3:0] v);
        return (v >= 4'd10) ? (8'd55 + {4'd0, v}) : (8'd48 + {4'd0, v});
    endfunction

endpackage

/* src/lcdn_if.sv */
// Request channel.
interface lcdn_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [7:0]  byte_value;
    logic [15:0] exec_us;
    logic [7:0]  column;
    logic [7:0]  row;
    logic [15:0] number;

    modport source (output valid, operation, byte_value, exec_us, column, row, number,
                    input ready);
    modport sink   (input valid, operation, byte_value, exec_us, column, row, number,
                    output ready);
endinterface

// Pin state channel.
interface lcdn_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  data_pins;
    logic        rs_pin;
    logic        en_pin;
    logic [15:0] hold_us;
    logic        last;

    modport source (output valid, data_pins, rs_pin, en_pin, hold_us, last, input ready);
    modport sink   (input valid, data_pins, rs_pin, en_pin, hold_us, last, output ready);
endinterface

/* src/lcdn_div10.sv */
module lcdn_div10 (
    input  logic        i_clk,
    input  logic [15:0] i_num,
    output logic [15:0] o_quot
);
    logic [31:0] n_prod;
    logic [15:0] r_quot;

    // Divide by ten as a multiply by the reciprocal 0xCCCD / 2^19, exact for 16 bits.
    assign n_prod = {16'd0, i_num} * 32'h0000_CCCD;

    always_ff @(posedge i_clk) begin
        r_quot <= {3'd0, n_prod[31:19]};
    end

    assign o_quot = r_quot;
endmodule

/* src/char_lcd_nibble_interface_top.sv */
// Latency: the first pin state of a request is offered the cycle after it is accepted.
// Throughput: one pin state per cycle while the sink takes them; a request of up to 28
// pin states holds the block until its last pin state is taken, and the next request is
// taken in the cycle after its last pin state goes out. The microcode sequencer's step
// counter walks the pin states. Reset (synchronous, active low) returns the block to idle.
module char_lcd_nibble_interface_top (
    input  logic  i_clk,
    input  logic  i_rst_n,
    lcdn_in_if.sink    i_req,
    lcdn_out_if.source o_pin
);
    import lcdn_pkg::*;

    logic        r_busy;
    t_pc         r_pc;
    logic [1:0]  r_phase;
    logic [7:0]  r_bv;
    logic [15:0] r_exec;
    logic [7:0]  r_addr;
    logic [15:0] r_num;

    logic [15:0] quot;
    logic [15:0] digit_full;
    logic [7:0]  sel_byte;
    logic [15:0] sel_hold;
    t_uword      w;
    t_uword      w_next;
    t_uword      w_entry;
    t_pc         entry_pc;
    logic        in_acc;
    logic        out_acc;

    assign in_acc   = i_req.valid && i_req.ready;
    assign out_acc  = o_pin.valid && o_pin.ready;
    assign w        = ucode(r_pc);
    assign w_next   = ucode(r_pc + t_pc'(1));
    assign entry_pc = entry(t_op'(i_req.operation));
    assign w_entry  = ucode(entry_pc);

    // Quotient of the remaining decimal value, registered from r_num.
    lcdn_div10 u_div10 (
        .i_clk  (i_clk),
        .i_num  (r_num),
        .o_quot (quot)
    );

    assign digit_full = r_num - ({quot[12:0], 3'b000} + {quot[14:0], 1'b0});

    // Byte selected by the current microinstruction.
    always_comb begin
        unique case (w.src)
            SRC_CONST:  sel_byte = w.k;
            SRC_BYTE:   sel_byte = r_bv;
            SRC_ADDR:   sel_byte = r_addr;
            SRC_HEX_HI: sel_byte = hex_char(r_bv[7:4]);
            SRC_HEX_LO: sel_byte = hex_char(r_bv[3:0]);
            SRC_DIGIT:  sel_byte = {4'h3, digit_full[3:0]};
            default:    sel_byte = w.k;
        endcase
    end

    // Hold time of the final pin state of the microinstruction.
    always_comb begin
        unique case (w.hold)
            HOLD_30000: sel_hold = 16'd30000;
            HOLD_5000:  sel_hold = 16'd5000;
            HOLD_100:   sel_hold = 16'd100;
            HOLD_37:    sel_hold = 16'd37;
            HOLD_41:    sel_hold = 16'd41;
            HOLD_1640:  sel_hold = 16'd1640;
            HOLD_EXEC:  sel_hold = r_exec;
            default:    sel_hold = 16'd37;
        endcase
    end

    // Pin state of the current phase.
    assign o_pin.valid     = r_busy;
    assign o_pin.data_pins = r_phase[1] ? sel_byte[3:0] : sel_byte[7:4];
    assign o_pin.rs_pin    = w.rs;
    assign o_pin.en_pin    = !r_phase[0];
    assign o_pin.hold_us   = !r_phase[0] ? 16'd1 : (r_phase[1] ? sel_hold : 16'd0);
    assign o_pin.last      = (r_phase == PH_LAST) && w.fin;
    assign i_req.ready     = !r_busy;

    // Sequencer: step counter, phase counter and conditional loop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_pc    <= '0;
            r_phase <= '0;
        end else if (in_acc) begin
            r_busy  <= 1'b1;
            r_pc    <= entry_pc;
            r_phase <= w_entry.start_ph;
        end else if (out_acc) begin
            if (r_phase != PH_LAST) begin
                r_phase <= r_phase + 2'd1;
            end else if (w.fin) begin
                r_busy <= 1'b0;
            end else if (w.loop && (quot != 16'd0)) begin
                r_phase <= PH_BYTE;
            end else begin
                r_pc    <= r_pc + t_pc'(1);
                r_phase <= w_next.start_ph;
            end
        end
    end

    // Request operands; the decimal value shifts down one digit per loop pass.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_bv   <= i_req.byte_value;
            r_exec <= i_req.exec_us;
            r_addr <= 8'h80 + {i_req.row[1:0], 6'd0} + i_req.column;
            r_num  <= i_req.number;
        end else if (out_acc && (r_phase == PH_LAST) && w.loop) begin
            r_num <= quot;
        end
    end

    // A strobe state is always held one microsecond.
    a_strobe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pin.valid && o_pin.en_pin |-> o_pin.hold_us == 16'd1)
        else $error("strobe pin state not held 1 us");

    // The last pin state of a request has enable low.
    a_last_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pin.valid && o_pin.last |-> !o_pin.en_pin)
        else $error("last pin state with enable high");

    // After the last pin state is taken the block is idle and takes a request.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pin.valid && o_pin.ready && o_pin.last |=> !o_pin.valid && i_req.ready)
        else $error("block not idle after last pin state");

    // No request is taken while pin states are pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pin.valid |-> !i_req.ready)
        else $error("request taken while busy");

endmodule
